>>> rtl/cau_pkg.sv
// shared constants and codes for the complex arithmetic unit
package cau_pkg;

   localparam int DATA_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;

   // operation selector carried on the request tuser
   typedef enum logic [1:0] {
      KIND_ADD = 2'd0,
      KIND_SUB = 2'd1,
      KIND_MUL = 2'd2,
      KIND_DIV = 2'd3
   } kind_type;

   // result status carried on the response tuser
   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_DIV_ZERO = 2'd1,
      STATUS_SAT      = 2'd2
   } status_type;

endpackage

>>> rtl/complex_arithmetic_unit.sv
// complex add, subtract, multiply and divide on signed fixed point, fully pipelined
// throughput: one request per cycle unless a response is stuck in the output register
// depth is set by the divider, one quotient bit per stage
// the whole pipe holds while a response waits unaccepted in the output register
// reset is synchronous and clears only the valid bits, data registers are not reset
// results saturate to the word range; a zero divisor gives zero with divide-by-zero status
module complex_arithmetic_unit #(
   parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [4*DATA_WIDTH-1:0]   req_tdata,  // a_re, a_im, b_re, b_im
   input  logic [1:0]                req_tuser,  // kind
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [2*DATA_WIDTH-1:0]   rsp_tdata,  // res_re, res_im
   output logic [1:0]                rsp_tuser   // status
);
   import cau_pkg::*;

   localparam int W  = DATA_WIDTH;
   localparam int PW = 2 * W;
   localparam int SW = PW + 1;
   localparam int QB = PW + FRAC_BITS;

   localparam logic [PW-1:0] POS_LIM = {{(W+1){1'b0}}, {(W-1){1'b1}}};
   localparam logic [PW-1:0] NEG_LIM = {{W{1'b0}}, 1'b1, {(W-1){1'b0}}};
   localparam logic [W-1:0]  MAX_W   = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0]  MIN_W   = {1'b1, {(W-1){1'b0}}};

   typedef struct packed {
      logic          div;
      logic          zero;
      logic          neg_re;
      logic          neg_im;
      logic [PW-1:0] mag_re;
      logic [PW-1:0] mag_im;
      logic [PW-1:0] den;
      logic [PW-1:0] rem_re;
      logic [PW-1:0] rem_im;
      logic [W:0]    q_re;
      logic [W:0]    q_im;
      logic          stk_re;
      logic          stk_im;
   } dv_type;

   logic pipe_en;

   // whole pipe advances unless a response is stuck
   assign pipe_en    = !rsp_tvalid || rsp_tready;
   assign req_tready = pipe_en;

   // request unpacking
   logic signed [W-1:0] a_re, a_im, b_re, b_im;
   assign a_re = req_tdata[W-1:0];
   assign a_im = req_tdata[2*W-1:W];
   assign b_re = req_tdata[3*W-1:2*W];
   assign b_im = req_tdata[4*W-1:3*W];

   // stage 1: partial products
   logic signed [PW-1:0] p_rr_in, p_ii_in, p_ri_in, p_ir_in, p_br_in, p_bi_in;
   logic signed [PW-1:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff, p_br_ff, p_bi_ff;
   logic signed [W-1:0]  a_re_ff, a_im_ff, b_re_ff, b_im_ff;
   kind_type             kind1_ff;
   logic                 zero1_ff;
   logic                 v1_ff;

   assign p_rr_in = a_re * b_re;
   assign p_ii_in = a_im * b_im;
   assign p_ri_in = a_re * b_im;
   assign p_ir_in = a_im * b_re;
   assign p_br_in = b_re * b_re;
   assign p_bi_in = b_im * b_im;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (pipe_en) begin
         v1_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         kind1_ff <= kind_type'(req_tuser);
         zero1_ff <= (b_re == '0) && (b_im == '0);
         a_re_ff  <= a_re;
         a_im_ff  <= a_im;
         b_re_ff  <= b_re;
         b_im_ff  <= b_im;
         p_rr_ff  <= p_rr_in;
         p_ii_ff  <= p_ii_in;
         p_ri_ff  <= p_ri_in;
         p_ir_ff  <= p_ir_in;
         p_br_ff  <= p_br_in;
         p_bi_ff  <= p_bi_in;
      end
   end

   // stage 2: sums per operation and divisor
   logic signed [SW-1:0] sre_in, sim_in, sre_ff, sim_ff;
   logic [PW-1:0]        den_in, den2_ff;
   kind_type             kind2_ff;
   logic                 zero2_ff;
   logic                 v2_ff;

   always_comb begin
      case (kind1_ff)
         KIND_ADD: begin
            sre_in = SW'(a_re_ff) + SW'(b_re_ff);
            sim_in = SW'(a_im_ff) + SW'(b_im_ff);
         end
         KIND_SUB: begin
            sre_in = SW'(a_re_ff) - SW'(b_re_ff);
            sim_in = SW'(a_im_ff) - SW'(b_im_ff);
         end
         KIND_MUL: begin
            sre_in = SW'(p_rr_ff) - SW'(p_ii_ff);
            sim_in = SW'(p_ri_ff) + SW'(p_ir_ff);
         end
         default: begin
            sre_in = SW'(p_rr_ff) + SW'(p_ii_ff);
            sim_in = SW'(p_ir_ff) - SW'(p_ri_ff);
         end
      endcase
      den_in = $unsigned(p_br_ff) + $unsigned(p_bi_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (pipe_en) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         sre_ff   <= sre_in;
         sim_ff   <= sim_in;
         den2_ff  <= den_in;
         kind2_ff <= kind1_ff;
         zero2_ff <= zero1_ff;
      end
   end

   // stage 3: sign and magnitude, product rescale, divider setup
   dv_type         dv_ff [0:QB];
   logic [0:QB]    dvv_ff;
   dv_type         dv0_in;
   logic [SW-1:0]  abs_re, abs_im;

   always_comb begin
      abs_re        = sre_ff[SW-1] ? -sre_ff : sre_ff;
      abs_im        = sim_ff[SW-1] ? -sim_ff : sim_ff;
      dv0_in        = '0;
      dv0_in.div    = (kind2_ff == KIND_DIV);
      dv0_in.zero   = zero2_ff;
      dv0_in.neg_re = sre_ff[SW-1];
      dv0_in.neg_im = sim_ff[SW-1];
      dv0_in.den    = den2_ff;
      if (kind2_ff == KIND_MUL) begin
         dv0_in.mag_re = abs_re[PW-1:0] >> FRAC_BITS;
         dv0_in.mag_im = abs_im[PW-1:0] >> FRAC_BITS;
      end else begin
         dv0_in.mag_re = abs_re[PW-1:0];
         dv0_in.mag_im = abs_im[PW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dvv_ff[0] <= 1'b0;
      end else if (pipe_en) begin
         dvv_ff[0] <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         dv_ff[0] <= dv0_in;
      end
   end

   // divider stages: one restoring step per stage on both parts
   for (genvar j = 0; j < QB; j++) begin : g_div
      logic          bit_re, bit_im;
      logic [PW:0]   r2_re, r2_im;
      logic          ge_re, ge_im;
      dv_type        nx;

      if (j < PW) begin : g_num
         assign bit_re = dv_ff[j].mag_re[PW-1-j];
         assign bit_im = dv_ff[j].mag_im[PW-1-j];
      end else begin : g_frac
         assign bit_re = 1'b0;
         assign bit_im = 1'b0;
      end

      always_comb begin
         nx        = dv_ff[j];
         r2_re     = {dv_ff[j].rem_re, bit_re};
         r2_im     = {dv_ff[j].rem_im, bit_im};
         ge_re     = r2_re >= {1'b0, dv_ff[j].den};
         ge_im     = r2_im >= {1'b0, dv_ff[j].den};
         nx.rem_re = ge_re ? PW'(r2_re - {1'b0, dv_ff[j].den}) : r2_re[PW-1:0];
         nx.rem_im = ge_im ? PW'(r2_im - {1'b0, dv_ff[j].den}) : r2_im[PW-1:0];
         nx.q_re   = {dv_ff[j].q_re[W-1:0], ge_re};
         nx.q_im   = {dv_ff[j].q_im[W-1:0], ge_im};
         nx.stk_re = dv_ff[j].stk_re | dv_ff[j].q_re[W];
         nx.stk_im = dv_ff[j].stk_im | dv_ff[j].q_im[W];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dvv_ff[j+1] <= 1'b0;
         end else if (pipe_en) begin
            dvv_ff[j+1] <= dvv_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if (pipe_en) begin
            dv_ff[j+1] <= nx;
         end
      end
   end

   // output stage: pick magnitude, saturate, sign, status
   dv_type           last;
   logic [PW-1:0]    val_re, val_im;
   logic             ovf_re, ovf_im;
   logic [W-1:0]     res_re_in, res_im_in;
   status_type       status_in;
   logic             rsp_tvalid_ff;
   logic [2*W-1:0]   rsp_tdata_ff;
   status_type       rsp_tuser_ff;

   always_comb begin
      last   = dv_ff[QB];
      val_re = last.div ? PW'(last.q_re) : last.mag_re;
      val_im = last.div ? PW'(last.q_im) : last.mag_im;
      ovf_re = (last.div && last.stk_re) || (val_re > (last.neg_re ? NEG_LIM : POS_LIM));
      ovf_im = (last.div && last.stk_im) || (val_im > (last.neg_im ? NEG_LIM : POS_LIM));
      if (ovf_re) begin
         res_re_in = last.neg_re ? MIN_W : MAX_W;
      end else begin
         res_re_in = last.neg_re ? W'(PW'(0) - val_re) : val_re[W-1:0];
      end
      if (ovf_im) begin
         res_im_in = last.neg_im ? MIN_W : MAX_W;
      end else begin
         res_im_in = last.neg_im ? W'(PW'(0) - val_im) : val_im[W-1:0];
      end
      status_in = (ovf_re || ovf_im) ? STATUS_SAT : STATUS_OK;
      if (last.div && last.zero) begin
         res_re_in = '0;
         res_im_in = '0;
         status_in = STATUS_DIV_ZERO;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (pipe_en) begin
         rsp_tvalid_ff <= dvv_ff[QB];
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         rsp_tdata_ff <= {res_im_in, res_re_in};
         rsp_tuser_ff <= status_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   // a divide-by-zero response carries zero parts
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == STATUS_DIV_ZERO) |-> (rsp_tdata == '0))
      else $error("divide by zero response with nonzero data");

   // restoring division keeps the remainder below the divisor
   assert property (@(posedge clock) disable iff (reset)
      dvv_ff[QB] && dv_ff[QB].div && !dv_ff[QB].zero
      |-> (dv_ff[QB].rem_re < dv_ff[QB].den) && (dv_ff[QB].rem_im < dv_ff[QB].den))
      else $error("divider remainder not below divisor");

   // an accepted request enters the first stage
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> v1_ff)
      else $error("accepted request lost at pipe entry");

endmodule

>>> verif/testbench.sv
// self-checking testbench for the complex arithmetic unit
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import cau_pkg::*;

   localparam int DW = DATA_WIDTH_DEF;
   localparam int FB = FRAC_BITS_DEF;
   localparam int LATENCY = 2 * DW + FB + 4;
   localparam int IDLE_LIMIT = 20000;
   localparam logic [63:0] POS_MAX = 64'((65'(1) << (DW - 1)) - 65'(1));
   localparam logic [63:0] NEG_MAX = 64'(1) << (DW - 1);

   typedef struct packed {
      logic [DW-1:0] res_re;
      logic [DW-1:0] res_im;
      status_type    status;
   } answer_t;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [4*DW-1:0] req_tdata = '0;
   logic [1:0] req_tuser = KIND_ADD;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [2*DW-1:0] rsp_tdata;
   logic [1:0] rsp_tuser;

   answer_t answers_due[$];
   int errors = 0;
   int idle_cycles = 0;
   bit hold_off = 0;
   bit stall_on = 1;
   bit bursty = 1;
   int burst_left = 0;

   complex_arithmetic_unit dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // sign-magnitude helpers for an exact prediction
   function automatic logic [63:0] mag_of(logic signed [DW-1:0] v);
      return v < 0 ? 64'(-65'(v)) : 64'(v);
   endfunction

   // add two signed-magnitude values, zero carries no sign
   function automatic void sm_add(input bit pn, input logic [63:0] pm, input bit qn,
                                  input logic [63:0] qm, output bit rn, output logic [63:0] rm);
      if (pn == qn) begin
         rn = pn;
         rm = pm + qm;
      end else if (pm >= qm) begin
         rn = pn;
         rm = pm - qm;
      end else begin
         rn = qn;
         rm = qm - pm;
      end
      if (rm == 0) rn = 0;
   endfunction

   function automatic logic [DW-1:0] saturate(bit n, logic [63:0] m, ref bit ovf);
      logic [63:0] lim;
      lim = n ? NEG_MAX : POS_MAX;
      if (m > lim) begin
         ovf = 1;
         m = lim;
      end
      return n ? DW'(-m) : DW'(m);
   endfunction

   // fixed-point quotient truncated toward zero, saturating on a large quotient
   function automatic logic [63:0] quotient(bit n, logic [63:0] num, logic [63:0] d,
                                            ref bit ovf);
      logic [63:0] lim, q, r;
      lim = n ? NEG_MAX : POS_MAX;
      q = num / d;
      r = num % d;
      if (q > (lim >> FB)) begin
         ovf = 1;
         return lim;
      end
      q = q << FB;
      for (int i = FB - 1; i >= 0; i--) begin
         r = r << 1;
         if (r >= d) begin
            r = r - d;
            q[i] = 1;
         end
      end
      return q;
   endfunction

   function automatic answer_t complex_result(kind_type k, logic signed [DW-1:0] ar,
         logic signed [DW-1:0] ai, logic signed [DW-1:0] br, logic signed [DW-1:0] bi);
      answer_t a;
      bit rn, inn, ovf, n1, n2;
      logic [63:0] rm, im, d;
      ovf = 0;
      case (k)
         KIND_ADD: begin
            sm_add(ar < 0, mag_of(ar), br < 0, mag_of(br), rn, rm);
            sm_add(ai < 0, mag_of(ai), bi < 0, mag_of(bi), inn, im);
         end
         KIND_SUB: begin
            sm_add(ar < 0, mag_of(ar), !(br < 0), mag_of(br), rn, rm);
            sm_add(ai < 0, mag_of(ai), !(bi < 0), mag_of(bi), inn, im);
         end
         KIND_MUL: begin
            n1 = (ar < 0) != (br < 0);
            n2 = (ai < 0) == (bi < 0);
            sm_add(n1, mag_of(ar) * mag_of(br), n2, mag_of(ai) * mag_of(bi), rn, rm);
            n1 = (ar < 0) != (bi < 0);
            n2 = (br < 0) != (ai < 0);
            sm_add(n1, mag_of(ar) * mag_of(bi), n2, mag_of(br) * mag_of(ai), inn, im);
            rm = rm >> FB;
            im = im >> FB;
            if (rm == 0) rn = 0;
            if (im == 0) inn = 0;
         end
         default: begin
            d = mag_of(br) * mag_of(br) + mag_of(bi) * mag_of(bi);
            if (d == 0) begin
               a.res_re = '0;
               a.res_im = '0;
               a.status = STATUS_DIV_ZERO;
               return a;
            end
            n1 = (ar < 0) != (br < 0);
            n2 = (ai < 0) != (bi < 0);
            sm_add(n1, mag_of(ar) * mag_of(br), n2, mag_of(ai) * mag_of(bi), rn, rm);
            n1 = (ai < 0) != (br < 0);
            n2 = (ar < 0) == (bi < 0);
            sm_add(n1, mag_of(ai) * mag_of(br), n2, mag_of(ar) * mag_of(bi), inn, im);
            rm = quotient(rn, rm, d, ovf);
            im = quotient(inn, im, d, ovf);
            if (rm == 0) rn = 0;
            if (im == 0) inn = 0;
         end
      endcase
      a.res_re = saturate(rn, rm, ovf);
      a.res_im = saturate(inn, im, ovf);
      a.status = ovf ? STATUS_SAT : STATUS_OK;
      return a;
   endfunction

   task automatic report(string what, logic [DW-1:0] got, logic [DW-1:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // send one request, with bursts and gaps between them
   task automatic send_request(kind_type k, logic [DW-1:0] ar, logic [DW-1:0] ai,
                               logic [DW-1:0] br, logic [DW-1:0] bi);
      int gap;
      if (bursty && burst_left == 0) begin
         gap = $urandom_range(0, 4);
         if (gap > 0) begin
            req_tvalid <= 0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      if (burst_left > 0) burst_left--;
      req_tvalid <= 1;
      req_tuser <= k;
      req_tdata <= {bi, br, ai, ar};
      answers_due.push_back(complex_result(k, ar, ai, br, bi));
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic release_request();
      req_tvalid <= 0;
      @(negedge clock);
   endtask

   // mostly interesting values: extremes, small integers, near zero, random
   function automatic logic [DW-1:0] pick_value();
      case ($urandom_range(0, 7))
         0: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, {(DW-1){$urandom_range(0, 1) == 1}}};
         1: return DW'($signed($urandom_range(0, 20)) - 10) << FB;
         2: return DW'($signed($urandom_range(0, 512)) - 256);
         3: return DW'($signed($urandom_range(0, 2000000)) - 1000000);
         4: return 0;
         default: return DW'($urandom);
      endcase
   endfunction

   task automatic test_extremes();
      logic [DW-1:0] v[5];
      v = '{32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'hffff_ffff, 32'h0001_0000};
      for (int k = 0; k < 4; k++) begin
         send_request(kind_type'(k), v[0], v[1], v[0], v[1]);
         send_request(kind_type'(k), v[1], v[1], v[1], v[1]);
         send_request(kind_type'(k), v[0], v[0], v[3], v[4]);
         send_request(kind_type'(k), v[3], v[4], v[4], v[3]);
      end
      // divide by zero, large and tiny quotients, exact zero results
      send_request(KIND_DIV, v[0], v[1], v[2], v[2]);
      send_request(KIND_DIV, v[2], v[2], v[2], v[2]);
      send_request(KIND_DIV, v[0], v[0], v[3], v[2]);
      send_request(KIND_DIV, v[3], v[2], v[0], v[0]);
      send_request(KIND_MUL, v[3], v[2], v[3], v[2]);
      send_request(KIND_SUB, v[4], v[4], v[4], v[4]);
      release_request();
   endtask

   task automatic test_random(int count);
      for (int i = 0; i < count; i++) begin
         bursty = (i % 200) < 150;
         send_request(kind_type'($urandom_range(0, 3)), pick_value(), pick_value(),
                      pick_value(), pick_value());
      end
      release_request();
   endtask

   // receiver holds off long enough for the pipe to fill and stall the sender
   task automatic test_backpressure();
      bursty = 0;
      hold_off = 1;
      fork
         test_random(LATENCY + 60);
         begin
            repeat (LATENCY + 150) @(negedge clock);
            hold_off = 0;
         end
      join
      bursty = 1;
   endtask

   task automatic drain();
      while (answers_due.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   // receiver stall pattern
   always @(negedge clock) begin
      if (($urandom_range(0, 299)) == 0) stall_on = !stall_on;
      rsp_tready <= !hold_off && (!stall_on || $urandom_range(0, 3) != 0);
   end

   // result checker and watchdog
   always @(posedge clock) begin
      answer_t want;
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles > IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (answers_due.size() == 0) begin
            report("unexpected response", rsp_tdata[DW-1:0], '0);
         end else begin
            want = answers_due.pop_front();
            if (rsp_tdata[DW-1:0] !== want.res_re)
               report("res_re", rsp_tdata[DW-1:0], want.res_re);
            if (rsp_tdata[2*DW-1:DW] !== want.res_im)
               report("res_im", rsp_tdata[2*DW-1:DW], want.res_im);
            if (rsp_tuser !== want.status)
               report("status", DW'(rsp_tuser), DW'(want.status));
         end
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      test_extremes();
      test_backpressure();
      test_random(600);
      drain();
      if (answers_due.size() != 0) errors++;
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule

>>> files.f
rtl/cau_pkg.sv
rtl/complex_arithmetic_unit.sv
verif/testbench.sv
